// ----- hdl/ilbm_pkg.sv -----
// Shared types and constants for the IFF picture body decoder.
// Used by the front, queue, back and top-level modules.
package ilbm_pkg;

	typedef enum logic [1:0] {
		MODE_CTRL    = 2'd0,
		MODE_LITERAL = 2'd1,
		MODE_REPEAT  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_FILL = 2'd1,
		BK_EMIT = 2'd2
	} back_state_t;

	localparam logic [7:0] CTRL_NOP = 8'h80;
	localparam logic [1:0] CFG_DITHER_ENABLE = 2'd0;
	localparam logic [1:0] CFG_DITHER_TABLE  = 2'd1;

	// One command from the front to the back: write this byte count times.
	typedef struct packed {
		logic       clear;
		logic [7:0] value;
		logic [7:0] count;
	} cmd_t;

endpackage

// ----- hdl/ilbm_byterun_planar_decoder.sv -----
// Top level of the ByteRun1 picture body decoder with planar-to-chunky output.
// Depends on ilbm_pkg, ilbm_front, ilbm_queue and ilbm_back.
// Body words are accepted while the command queue has room. The row engine takes a new
// command only in its idle state, and every full row then reads the planes of each
// eight-pixel group from the single-port store, so while a row of 40 groups is emitted,
// words queue up and stall.
module ilbm_byterun_planar_decoder #(
	parameter int LINE_BYTES = 160,
	parameter int PLANES = 4,
	parameter int MAX_ROWS = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tuser,  // first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // row, group, pixel_0..pixel_7, zero pad
	output logic        m_tlast,  // row_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	ilbm_pkg::cmd_t fcmd, qcmd;
	logic fv, fr, qv, qr;
	logic den_q;
	logic [63:0] dtab_q;
	logic [7:0] row;
	logic [5:0] group;
	logic [31:0] pixels;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= 1'b0;
			dtab_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == ilbm_pkg::CFG_DITHER_ENABLE) den_q <= cfg_data[0];
			if (cfg_index == ilbm_pkg::CFG_DITHER_TABLE) dtab_q <= cfg_data;
		end
	end

	ilbm_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .first(s_tuser),
		.data_byte(s_tdata), .cmd_valid(fv), .cmd(fcmd), .cmd_ready(fr)
	);

	ilbm_queue #(.DEPTH_LOG2(2)) u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_cmd(fcmd),
		.rd_valid(qv), .rd_ready(qr), .rd_cmd(qcmd)
	);

	ilbm_back #(.LINE_BYTES(LINE_BYTES), .PLANES(PLANES), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk, .arst_n, .cmd_valid(qv), .cmd_ready(qr), .cmd(qcmd),
		.dither_enable(den_q), .dither_table(dtab_q), .out_valid(m_tvalid),
		.out_ready(m_tready), .row, .group, .pixels, .row_end(m_tlast)
	);

	assign m_tdata = {2'b00, pixels, group, row};
endmodule

// ----- hdl/ilbm_front.sv -----
// Front part: accepts body words and parses the ByteRun1 control structure.
// Depends on ilbm_pkg; produces run commands into the command queue.
module ilbm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               first,
	input  logic [7:0]         data_byte,
	output logic               cmd_valid,
	output ilbm_pkg::cmd_t     cmd,
	input  logic               cmd_ready
);
	ilbm_pkg::mode_t mode_q;
	logic [7:0] run_q;
	ilbm_pkg::mode_t mode_eff;

	assign in_ready = cmd_ready;
	assign mode_eff = first ? ilbm_pkg::MODE_CTRL : mode_q;

	always_comb begin
		cmd.clear = first;
		cmd.value = data_byte;
		cmd.count = 8'd0;
		cmd_valid = 1'b0;
		if (in_valid && cmd_ready) begin
			case (mode_eff)
				ilbm_pkg::MODE_LITERAL: begin
					cmd.count = 8'd1;
					cmd_valid = 1'b1;
				end
				ilbm_pkg::MODE_REPEAT: begin
					cmd.count = run_q;
					cmd_valid = 1'b1;
				end
				default: begin
					cmd_valid = first;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ilbm_pkg::MODE_CTRL;
			run_q  <= 8'd0;
		end else if (in_valid && cmd_ready) begin
			case (mode_eff)
				ilbm_pkg::MODE_LITERAL: begin
					run_q <= run_q - 8'd1;
					if (run_q <= 8'd1) begin
						mode_q <= ilbm_pkg::MODE_CTRL;
					end
				end
				ilbm_pkg::MODE_REPEAT: begin
					run_q  <= 8'd0;
					mode_q <= ilbm_pkg::MODE_CTRL;
				end
				default: begin
					if (data_byte == ilbm_pkg::CTRL_NOP) begin
						mode_q <= ilbm_pkg::MODE_CTRL;
						run_q  <= first ? 8'd0 : run_q;
					end else if (data_byte[7]) begin
						run_q  <= 8'd1 - data_byte;
						mode_q <= ilbm_pkg::MODE_REPEAT;
					end else begin
						run_q  <= data_byte + 8'd1;
						mode_q <= ilbm_pkg::MODE_LITERAL;
					end
				end
			endcase
		end
	end
endmodule

// ----- hdl/ilbm_queue.sv -----
// Short command queue between the parser and the row engine.
// Depends on ilbm_pkg for the command type.
module ilbm_queue #(
	parameter int DEPTH_LOG2 = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  ilbm_pkg::cmd_t wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output ilbm_pkg::cmd_t rd_cmd
);
	localparam int DEPTH = 1 << DEPTH_LOG2;
	ilbm_pkg::cmd_t mem_q [DEPTH];
	logic [DEPTH_LOG2:0] wp_q, rp_q;

	assign wr_ready = (wp_q - rp_q) != DEPTH[DEPTH_LOG2:0];
	assign rd_valid = wp_q != rp_q;
	assign rd_cmd   = mem_q[rp_q[DEPTH_LOG2-1:0]];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) begin
			mem_q[wp_q[DEPTH_LOG2-1:0]] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= wp_q + 1'b1;
			if (rd_valid && rd_ready) rp_q <= rp_q + 1'b1;
		end
	end
endmodule

// ----- hdl/ilbm_back.sv -----
// Back part: writes run bytes into the row store and emits pixel groups.
// Depends on ilbm_pkg; holds the row store memory and the output register.
module ilbm_back #(
	parameter int LINE_BYTES = 160,
	parameter int PLANES = 4,
	parameter int MAX_ROWS = 200
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  ilbm_pkg::cmd_t cmd,
	input  logic           dither_enable,
	input  logic [63:0]    dither_table,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     row,
	output logic [5:0]     group,
	output logic [31:0]    pixels,
	output logic           row_end
);
	localparam int PSIZE = LINE_BYTES / PLANES;
	localparam int AW = $clog2(LINE_BYTES);
	localparam int GW = (PSIZE > 1) ? $clog2(PSIZE) : 1;
	localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int EP = (PLANES < 4) ? PLANES : 4;

	logic [7:0] store_q [LINE_BYTES];
	ilbm_pkg::back_state_t st_q, st_d;
	logic [AW-1:0] wpos_q;
	logic [RW-1:0] rows_q;
	logic [7:0] value_q, left_q;
	logic [GW-1:0] g_q;
	logic [PW:0] p_q;
	logic [7:0] planes_q [EP];
	logic [7:0] rd_s1;
	logic rd_v_s1;
	logic [PW-1:0] rd_p_s1;
	logic [AW-1:0] rd_addr;
	logic done;
	logic wr_en, rd_en, grp_ready;
	logic emit_fire;

	assign done = rows_q >= RW'(MAX_ROWS);
	assign rd_addr = AW'(p_q[PW-1:0] * PSIZE + g_q);
	assign wr_en = st_q == ilbm_pkg::BK_FILL && left_q != 8'd0;
	assign grp_ready = !out_valid || out_ready;
	assign rd_en = st_q == ilbm_pkg::BK_EMIT && p_q < (PW+1)'(EP);
	assign emit_fire = st_q == ilbm_pkg::BK_EMIT && !rd_en && !rd_v_s1 && grp_ready;

	always_comb begin
		st_d = st_q;
		cmd_ready = 1'b0;
		case (st_q)
			ilbm_pkg::BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && !cmd.clear && !done) st_d = ilbm_pkg::BK_FILL;
			end
			ilbm_pkg::BK_FILL: begin
				if (left_q == 8'd0) begin
					st_d = ilbm_pkg::BK_IDLE;
				end else if (32'(wpos_q) == LINE_BYTES - 1) begin
					st_d = ilbm_pkg::BK_EMIT;
				end
			end
			ilbm_pkg::BK_EMIT: begin
				if (!rd_en && !rd_v_s1 && grp_ready && 32'(g_q) == PSIZE - 1) begin
					st_d = done ? ilbm_pkg::BK_IDLE : ilbm_pkg::BK_FILL;
				end
			end
			default: st_d = ilbm_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) store_q[wpos_q] <= value_q;
		if (rd_en) rd_s1 <= store_q[rd_addr];
		if (rd_v_s1) planes_q[rd_p_s1] <= rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ilbm_pkg::BK_IDLE;
			wpos_q <= '0;
			rows_q <= '0;
			value_q <= '0;
			left_q <= '0;
			g_q <= '0;
			p_q <= '0;
			rd_v_s1 <= 1'b0;
			rd_p_s1 <= '0;
			out_valid <= 1'b0;
			row <= '0;
			group <= '0;
			pixels <= '0;
			row_end <= 1'b0;
		end else begin
			st_q <= st_d;
			rd_v_s1 <= rd_en;
			rd_p_s1 <= p_q[PW-1:0];
			if (out_valid && out_ready && !emit_fire) out_valid <= 1'b0;
			case (st_q)
				ilbm_pkg::BK_IDLE: begin
					if (cmd_valid) begin
						if (cmd.clear) begin
							wpos_q <= '0;
							rows_q <= '0;
							left_q <= '0;
						end else begin
							value_q <= cmd.value;
							left_q <= cmd.count;
						end
					end
				end
				ilbm_pkg::BK_FILL: begin
					if (left_q != 8'd0) begin
						left_q <= left_q - 8'd1;
						if (32'(wpos_q) == LINE_BYTES - 1) begin
							wpos_q <= '0;
							g_q <= '0;
							p_q <= '0;
						end else begin
							wpos_q <= wpos_q + 1'b1;
						end
					end
				end
				ilbm_pkg::BK_EMIT: begin
					if (rd_en) p_q <= p_q + 1'b1;
					if (emit_fire) begin
						out_valid <= 1'b1;
						row <= 8'(rows_q);
						group <= 6'(g_q);
						row_end <= 32'(g_q) == PSIZE - 1;
						for (int i = 0; i < 8; i++) begin
							logic [3:0] c;
							c = '0;
							for (int b = 0; b < EP; b++) c[b] = planes_q[b][7-i];
							if (dither_enable) begin
								c = {2'b00, dither_table[{rows_q[0], c, 1'b0} +: 2]};
							end
							pixels[4*i +: 4] <= c;
						end
						if (32'(g_q) == PSIZE - 1) begin
							rows_q <= rows_q + 1'b1;
							if (rows_q + 1'b1 >= RW'(MAX_ROWS)) left_q <= '0;
						end else begin
							g_q <= g_q + 1'b1;
							p_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
